FILE: hw/rtl/fis_pkg.sv
// ----------------------------------------------------------------------------
// fis_pkg: fractal iteration step shared definitions
// Word format, formula and class codes, queue item layout and the saturating
// fixed-point helpers used by the front, the queue and the back pipeline.
// ----------------------------------------------------------------------------
package fis_pkg;

   localparam int WORD_WIDTH  = 32;
   localparam int FRAC_BITS   = 28;
   localparam int PROD_WIDTH  = 2 * WORD_WIDTH;
   localparam int DIV_LAT     = WORD_WIDTH + 2;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   typedef logic signed [WORD_WIDTH-1:0] word_type;
   typedef logic signed [PROD_WIDTH-1:0] prod_type;

   localparam word_type WORD_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};
   localparam prod_type PROD_WMAX = {{(WORD_WIDTH+1){1'b0}}, {(WORD_WIDTH-1){1'b1}}};
   localparam prod_type PROD_WMIN = {{(WORD_WIDTH+1){1'b1}}, {(WORD_WIDTH-1){1'b0}}};

   localparam word_type OFFSET_RESET = word_type'(-32'sd376119681);

   // formula modes that differ from the plain quadratic
   localparam logic [2:0] FUNC_SHIP  = 3'd2;
   localparam logic [2:0] FUNC_CDIV  = 3'd3;
   localparam logic [2:0] FUNC_CUBIC = 3'd4;

   // item class seen by the back pipeline
   localparam logic [1:0] CLS_QUAD  = 2'd0;
   localparam logic [1:0] CLS_CUBIC = 2'd1;
   localparam logic [1:0] CLS_CDIV  = 2'd2;

   localparam logic CSR_IDX_OFFSET = 1'b0;

   typedef struct packed {
      logic [1:0] cls;
      logic       ovf;
      word_type   z_re;
      word_type   z_im;
      word_type   c_re;
      word_type   c_im;
      word_type   k;
   } queue_entry_type;

   typedef struct packed {
      logic     ovf;
      word_type val;
   } sat_type;

   function automatic sat_type mul_fin(prod_type p);
      prod_type sh;
      sat_type  r;
      sh = p >>> FRAC_BITS;
      if (sh > PROD_WMAX) begin
         r.ovf = 1'b1;
         r.val = WORD_MAX;
      end else if (sh < PROD_WMIN) begin
         r.ovf = 1'b1;
         r.val = WORD_MIN;
      end else begin
         r.ovf = 1'b0;
         r.val = sh[WORD_WIDTH-1:0];
      end
      return r;
   endfunction

   function automatic sat_type sat_add(word_type a, word_type b);
      logic signed [WORD_WIDTH:0] s;
      sat_type r;
      s = {a[WORD_WIDTH-1], a} + {b[WORD_WIDTH-1], b};
      r.ovf = s[WORD_WIDTH] != s[WORD_WIDTH-1];
      r.val = r.ovf ? (s[WORD_WIDTH] ? WORD_MIN : WORD_MAX) : s[WORD_WIDTH-1:0];
      return r;
   endfunction

   function automatic sat_type sat_sub(word_type a, word_type b);
      logic signed [WORD_WIDTH:0] s;
      sat_type r;
      s = {a[WORD_WIDTH-1], a} - {b[WORD_WIDTH-1], b};
      r.ovf = s[WORD_WIDTH] != s[WORD_WIDTH-1];
      r.val = r.ovf ? (s[WORD_WIDTH] ? WORD_MIN : WORD_MAX) : s[WORD_WIDTH-1:0];
      return r;
   endfunction

endpackage

FILE: hw/rtl/fis_req_if.sv
// ----------------------------------------------------------------------------
// fis_req_if: request channel
// Valid/ready channel carrying one iteration item.
// ----------------------------------------------------------------------------
interface fis_req_if;
   import fis_pkg::*;

   logic       valid;
   logic       ready;
   logic [2:0] func;
   word_type   z_re;
   word_type   z_im;
   word_type   c_re;
   word_type   c_im;

   modport source (output valid, func, z_re, z_im, c_re, c_im, input ready);
   modport sink (input valid, func, z_re, z_im, c_re, c_im, output ready);

endinterface

FILE: hw/rtl/fis_rsp_if.sv
// ----------------------------------------------------------------------------
// fis_rsp_if: response channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface fis_rsp_if;
   import fis_pkg::*;

   logic     valid;
   logic     ready;
   word_type next_re;
   word_type next_im;
   logic     overflow;
   logic     divide_by_zero;

   modport source (output valid, next_re, next_im, overflow, divide_by_zero, input ready);
   modport sink (input valid, next_re, next_im, overflow, divide_by_zero, output ready);

endinterface

FILE: hw/rtl/fis_front.sv
// ----------------------------------------------------------------------------
// fis_front: request front end
// Accepts items, sorts them by formula class and folds burning ship into
// the quadratic path by taking absolute values of z.
// ----------------------------------------------------------------------------
module fis_front (
   fis_req_if.sink                req_ch,
   input  fis_pkg::word_type      cubic_offset,
   input  logic                   q_full,
   output logic                   q_push,
   output fis_pkg::queue_entry_type q_entry
);
   import fis_pkg::*;

   logic ovf_re;
   logic ovf_im;

   assign req_ch.ready = !q_full;
   assign q_push       = req_ch.valid && !q_full;

   always_comb begin
      q_entry.c_re = req_ch.c_re;
      q_entry.c_im = req_ch.c_im;
      q_entry.k    = cubic_offset;
      q_entry.z_re = req_ch.z_re;
      q_entry.z_im = req_ch.z_im;
      ovf_re       = 1'b0;
      ovf_im       = 1'b0;
      case (req_ch.func)
         FUNC_CDIV:  q_entry.cls = CLS_CDIV;
         FUNC_CUBIC: q_entry.cls = CLS_CUBIC;
         default:    q_entry.cls = CLS_QUAD;
      endcase
      if (req_ch.func == FUNC_SHIP) begin
         if (req_ch.z_re == WORD_MIN) begin
            ovf_re       = 1'b1;
            q_entry.z_re = WORD_MAX;
         end else if (req_ch.z_re < 0) begin
            q_entry.z_re = -req_ch.z_re;
         end
         if (req_ch.z_im == WORD_MIN) begin
            ovf_im       = 1'b1;
            q_entry.z_im = WORD_MAX;
         end else if (req_ch.z_im < 0) begin
            q_entry.z_im = -req_ch.z_im;
         end
      end
      q_entry.ovf = ovf_re | ovf_im;
   end

endmodule

FILE: hw/rtl/fis_queue.sv
// ----------------------------------------------------------------------------
// fis_queue: front to back item queue
// Short FIFO that lets the front and the back pipeline stall separately.
// ----------------------------------------------------------------------------
module fis_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  fis_pkg::queue_entry_type wr_entry,
   output logic                     full,
   input  logic                     pop,
   output fis_pkg::queue_entry_type rd_entry,
   output logic                     empty
);
   import fis_pkg::*;

   queue_entry_type          slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]        count_ff, count_in;

   assign full     = count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign rd_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wr_entry;
      end
   end

   a_no_overrun: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("item pushed into full queue");
   a_no_underrun: assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("item popped from empty queue");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue fill count lost an item");

endmodule

FILE: hw/rtl/fis_div.sv
// ----------------------------------------------------------------------------
// fis_div: pipelined fixed-point divider
// Restoring divider, one quotient bit per stage, giving the floor of
// num * 2^FRAC_BITS / den with saturation to the word range.
// ----------------------------------------------------------------------------
module fis_div (
   input  logic              clock,
   input  logic              en,
   input  fis_pkg::word_type num,
   input  fis_pkg::word_type den,
   output fis_pkg::word_type quo,
   output logic              ovf
);
   import fis_pkg::*;

   localparam int SHIFT = WORD_WIDTH - FRAC_BITS;
   localparam int NUM_W = WORD_WIDTH + FRAC_BITS;

   typedef struct packed {
      logic                  neg;
      logic                  big;
      logic [WORD_WIDTH-1:0] rem;
      logic [WORD_WIDTH-1:0] low;
      logic [WORD_WIDTH-1:0] quo;
      logic [WORD_WIDTH-1:0] den;
   } step_type;

   function automatic step_type div_step(step_type s);
      logic [WORD_WIDTH:0] trial;
      logic                ge;
      step_type            r;
      trial = {s.rem, s.low[WORD_WIDTH-1]};
      ge    = trial >= {1'b0, s.den};
      r     = s;
      r.rem = ge ? WORD_WIDTH'(trial - {1'b0, s.den}) : trial[WORD_WIDTH-1:0];
      r.low = {s.low[WORD_WIDTH-2:0], 1'b0};
      r.quo = {s.quo[WORD_WIDTH-2:0], ge};
      return r;
   endfunction

   step_type              st_ff [WORD_WIDTH+1];
   step_type              prep;
   logic [WORD_WIDTH-1:0] mag;
   logic [NUM_W-1:0]      nw;
   logic [WORD_WIDTH:0]   qinc;
   word_type              quo_ff, quo_in;
   logic                  ovf_ff, ovf_in;

   always_comb begin
      mag       = num[WORD_WIDTH-1] ? (~num + 1'b1) : num;
      nw        = {mag, {FRAC_BITS{1'b0}}};
      prep.neg  = num[WORD_WIDTH-1];
      prep.big  = {{SHIFT{1'b0}}, mag} >= {den, {SHIFT{1'b0}}};
      prep.rem  = WORD_WIDTH'(nw[NUM_W-1:WORD_WIDTH]);
      prep.low  = nw[WORD_WIDTH-1:0];
      prep.quo  = '0;
      prep.den  = den;
   end

   always_comb begin
      qinc = {1'b0, st_ff[WORD_WIDTH].quo}
           + {{WORD_WIDTH{1'b0}}, st_ff[WORD_WIDTH].neg && (st_ff[WORD_WIDTH].rem != '0)};
      ovf_in = 1'b0;
      if (st_ff[WORD_WIDTH].big) begin
         ovf_in = 1'b1;
         quo_in = st_ff[WORD_WIDTH].neg ? WORD_MIN : WORD_MAX;
      end else if (!st_ff[WORD_WIDTH].neg) begin
         if (qinc[WORD_WIDTH] || qinc[WORD_WIDTH-1]) begin
            ovf_in = 1'b1;
            quo_in = WORD_MAX;
         end else begin
            quo_in = qinc[WORD_WIDTH-1:0];
         end
      end else begin
         if (qinc[WORD_WIDTH] || (qinc[WORD_WIDTH-1] && (qinc[WORD_WIDTH-2:0] != '0))) begin
            ovf_in = 1'b1;
            quo_in = WORD_MIN;
         end else begin
            quo_in = -qinc[WORD_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff[0] <= prep;
         for (int k = 0; k < WORD_WIDTH; k++) begin
            st_ff[k+1] <= div_step(st_ff[k]);
         end
         quo_ff <= quo_in;
         ovf_ff <= ovf_in;
      end
   end

   assign quo = quo_ff;
   assign ovf = ovf_ff;

endmodule

FILE: hw/rtl/fis_back.sv
// ----------------------------------------------------------------------------
// fis_back: arithmetic back end
// Stall-together pipeline: z^2 and c^2, c^3, s, |s|^2 and numerators, then
// the divider, ending in the result register.
// ----------------------------------------------------------------------------
module fis_back (
   input  logic                     clock,
   input  logic                     reset,
   input  fis_pkg::queue_entry_type q_entry,
   input  logic                     q_empty,
   output logic                     q_pop,
   fis_rsp_if.source                rsp_ch
);
   import fis_pkg::*;

   localparam int FRONT_STAGES = 7;
   localparam int VLD_W = FRONT_STAGES + DIV_LAT;

   typedef struct packed {
      logic [1:0] cls;
      logic       ovf;
      word_type   c_re, c_im, k;
      prod_type   zrr, zii, zri, crr, cii, cri;
   } s1_type;

   typedef struct packed {
      logic [1:0] cls;
      logic       ovf_z, ovf_c;
      word_type   zz_re, zz_im, cc_re, cc_im, c_re, c_im, k;
   } s2_type;

   typedef struct packed {
      logic [1:0] cls;
      logic       ovf_z, ovf_q, ovf_c;
      word_type   zz_re, zz_im, q_re, q_im, k;
      prod_type   p_rr, p_ii, p_ri, p_ir;
   } s3_type;

   typedef struct packed {
      logic [1:0] cls;
      logic       ovf_z, ovf_q, ovf_c;
      word_type   zz_re, zz_im, q_re, q_im, k, c3_re, c3_im;
   } s4_type;

   typedef struct packed {
      logic [1:0] cls;
      logic       ovf_z, ovf_q, ovf_c;
      word_type   q_re, q_im, c3_re, c3_im, s_re, s_im;
   } s5_type;

   typedef struct packed {
      logic [1:0] cls;
      logic       ovf_z, ovf_q, ovf_c;
      word_type   q_re, q_im, s_re, s_im;
      prod_type   ss_rr, ss_ii, n_rr, n_ii, n_ir, n_ri;
   } s6_type;

   typedef struct packed {
      logic [1:0] cls;
      logic       ovf_z, ovf_q, ovf_c, ovf_d, ovf_n, d_zero;
      word_type   q_re, q_im, s_re, s_im;
   } side_type;

   s1_type   s1_ff, s1_in;
   s2_type   s2_ff, s2_in;
   s3_type   s3_ff, s3_in;
   s4_type   s4_ff, s4_in;
   s5_type   s5_ff, s5_in;
   s6_type   s6_ff, s6_in;
   side_type s7_ff, s7_in;
   word_type nr_ff, nr_in, ni_ff, ni_in, d_ff, d_in;
   side_type side_ff [DIV_LAT];
   logic [VLD_W-1:0] vld_ff;
   logic     out_vld_ff;
   word_type out_re_ff, out_re_in, out_im_ff, out_im_in;
   logic     out_ovf_ff, out_ovf_in, out_dz_ff, out_dz_in;
   logic     adv;
   word_type div_re, div_im;
   logic     div_re_ovf, div_im_ovf;

   assign adv   = !out_vld_ff || rsp_ch.ready;
   assign q_pop = adv && !q_empty;

   // stage 1: squares of z and c
   always_comb begin
      s1_in.cls  = q_entry.cls;
      s1_in.ovf  = q_entry.ovf;
      s1_in.c_re = q_entry.c_re;
      s1_in.c_im = q_entry.c_im;
      s1_in.k    = q_entry.k;
      s1_in.zrr  = q_entry.z_re * q_entry.z_re;
      s1_in.zii  = q_entry.z_im * q_entry.z_im;
      s1_in.zri  = q_entry.z_re * q_entry.z_im;
      s1_in.crr  = q_entry.c_re * q_entry.c_re;
      s1_in.cii  = q_entry.c_im * q_entry.c_im;
      s1_in.cri  = q_entry.c_re * q_entry.c_im;
   end

   // stage 2: z^2 and c^2
   always_comb begin
      sat_type a, b, c, re, im, e, f, g, cre, cim;
      a   = mul_fin(s1_ff.zrr);
      b   = mul_fin(s1_ff.zii);
      c   = mul_fin(s1_ff.zri);
      re  = sat_sub(a.val, b.val);
      im  = sat_add(c.val, c.val);
      e   = mul_fin(s1_ff.crr);
      f   = mul_fin(s1_ff.cii);
      g   = mul_fin(s1_ff.cri);
      cre = sat_sub(e.val, f.val);
      cim = sat_add(g.val, g.val);
      s2_in.cls   = s1_ff.cls;
      s2_in.ovf_z = s1_ff.ovf | a.ovf | b.ovf | c.ovf | re.ovf | im.ovf;
      s2_in.ovf_c = e.ovf | f.ovf | g.ovf | cre.ovf | cim.ovf;
      s2_in.zz_re = re.val;
      s2_in.zz_im = im.val;
      s2_in.cc_re = cre.val;
      s2_in.cc_im = cim.val;
      s2_in.c_re  = s1_ff.c_re;
      s2_in.c_im  = s1_ff.c_im;
      s2_in.k     = s1_ff.k;
   end

   // stage 3: c^2 * c products and the quadratic result
   always_comb begin
      sat_type qr, qi;
      qr = sat_add(s2_ff.zz_re, s2_ff.c_re);
      qi = sat_add(s2_ff.zz_im, s2_ff.c_im);
      s3_in.cls   = s2_ff.cls;
      s3_in.ovf_z = s2_ff.ovf_z;
      s3_in.ovf_q = qr.ovf | qi.ovf;
      s3_in.ovf_c = s2_ff.ovf_c;
      s3_in.zz_re = s2_ff.zz_re;
      s3_in.zz_im = s2_ff.zz_im;
      s3_in.q_re  = qr.val;
      s3_in.q_im  = qi.val;
      s3_in.k     = s2_ff.k;
      s3_in.p_rr  = s2_ff.cc_re * s2_ff.c_re;
      s3_in.p_ii  = s2_ff.cc_im * s2_ff.c_im;
      s3_in.p_ri  = s2_ff.cc_re * s2_ff.c_im;
      s3_in.p_ir  = s2_ff.cc_im * s2_ff.c_re;
   end

   // stage 4: c^3
   always_comb begin
      sat_type a, b, c, d, re, im;
      a  = mul_fin(s3_ff.p_rr);
      b  = mul_fin(s3_ff.p_ii);
      c  = mul_fin(s3_ff.p_ri);
      d  = mul_fin(s3_ff.p_ir);
      re = sat_sub(a.val, b.val);
      im = sat_add(c.val, d.val);
      s4_in.cls   = s3_ff.cls;
      s4_in.ovf_z = s3_ff.ovf_z;
      s4_in.ovf_q = s3_ff.ovf_q;
      s4_in.ovf_c = s3_ff.ovf_c | a.ovf | b.ovf | c.ovf | d.ovf | re.ovf | im.ovf;
      s4_in.zz_re = s3_ff.zz_re;
      s4_in.zz_im = s3_ff.zz_im;
      s4_in.q_re  = s3_ff.q_re;
      s4_in.q_im  = s3_ff.q_im;
      s4_in.k     = s3_ff.k;
      s4_in.c3_re = re.val;
      s4_in.c3_im = im.val;
   end

   // stage 5: s = z^2 + c^3 + k
   always_comb begin
      sat_type a, b, c;
      a = sat_add(s4_ff.zz_re, s4_ff.c3_re);
      b = sat_add(a.val, s4_ff.k);
      c = sat_add(s4_ff.zz_im, s4_ff.c3_im);
      s5_in.cls   = s4_ff.cls;
      s5_in.ovf_z = s4_ff.ovf_z;
      s5_in.ovf_q = s4_ff.ovf_q;
      s5_in.ovf_c = s4_ff.ovf_c | a.ovf | b.ovf | c.ovf;
      s5_in.q_re  = s4_ff.q_re;
      s5_in.q_im  = s4_ff.q_im;
      s5_in.c3_re = s4_ff.c3_re;
      s5_in.c3_im = s4_ff.c3_im;
      s5_in.s_re  = b.val;
      s5_in.s_im  = c.val;
   end

   // stage 6: |s|^2 and numerator products
   always_comb begin
      s6_in.cls   = s5_ff.cls;
      s6_in.ovf_z = s5_ff.ovf_z;
      s6_in.ovf_q = s5_ff.ovf_q;
      s6_in.ovf_c = s5_ff.ovf_c;
      s6_in.q_re  = s5_ff.q_re;
      s6_in.q_im  = s5_ff.q_im;
      s6_in.s_re  = s5_ff.s_re;
      s6_in.s_im  = s5_ff.s_im;
      s6_in.ss_rr = s5_ff.s_re * s5_ff.s_re;
      s6_in.ss_ii = s5_ff.s_im * s5_ff.s_im;
      s6_in.n_rr  = s5_ff.c3_re * s5_ff.s_re;
      s6_in.n_ii  = s5_ff.c3_im * s5_ff.s_im;
      s6_in.n_ir  = s5_ff.c3_im * s5_ff.s_re;
      s6_in.n_ri  = s5_ff.c3_re * s5_ff.s_im;
   end

   // stage 7: divisor and numerators
   always_comb begin
      sat_type a, b, c, d, e, f, dd, nr, ni;
      a  = mul_fin(s6_ff.ss_rr);
      b  = mul_fin(s6_ff.ss_ii);
      c  = mul_fin(s6_ff.n_rr);
      d  = mul_fin(s6_ff.n_ii);
      e  = mul_fin(s6_ff.n_ir);
      f  = mul_fin(s6_ff.n_ri);
      dd = sat_add(a.val, b.val);
      nr = sat_add(c.val, d.val);
      ni = sat_sub(e.val, f.val);
      s7_in.cls    = s6_ff.cls;
      s7_in.ovf_z  = s6_ff.ovf_z;
      s7_in.ovf_q  = s6_ff.ovf_q;
      s7_in.ovf_c  = s6_ff.ovf_c;
      s7_in.ovf_d  = a.ovf | b.ovf | dd.ovf;
      s7_in.ovf_n  = c.ovf | d.ovf | e.ovf | f.ovf | nr.ovf | ni.ovf;
      s7_in.d_zero = dd.val == '0;
      s7_in.q_re   = s6_ff.q_re;
      s7_in.q_im   = s6_ff.q_im;
      s7_in.s_re   = s6_ff.s_re;
      s7_in.s_im   = s6_ff.s_im;
      d_in         = dd.val;
      nr_in        = nr.val;
      ni_in        = ni.val;
   end

   fis_div u_div_re (
      .clock (clock),
      .en    (adv),
      .num   (nr_ff),
      .den   (d_ff),
      .quo   (div_re),
      .ovf   (div_re_ovf)
   );

   fis_div u_div_im (
      .clock (clock),
      .en    (adv),
      .num   (ni_ff),
      .den   (d_ff),
      .quo   (div_im),
      .ovf   (div_im_ovf)
   );

   // result select
   always_comb begin
      side_type t;
      t          = side_ff[DIV_LAT-1];
      out_dz_in  = 1'b0;
      out_re_in  = t.q_re;
      out_im_in  = t.q_im;
      out_ovf_in = t.ovf_z | t.ovf_q;
      case (t.cls)
         CLS_CUBIC: begin
            out_re_in  = t.s_re;
            out_im_in  = t.s_im;
            out_ovf_in = t.ovf_z | t.ovf_c;
         end
         CLS_CDIV: begin
            if (t.d_zero) begin
               out_re_in  = '0;
               out_im_in  = '0;
               out_dz_in  = 1'b1;
               out_ovf_in = t.ovf_z | t.ovf_c | t.ovf_d;
            end else begin
               out_re_in  = div_re;
               out_im_in  = div_im;
               out_ovf_in = t.ovf_z | t.ovf_c | t.ovf_d | t.ovf_n | div_re_ovf | div_im_ovf;
            end
         end
         default: begin
            out_re_in  = t.q_re;
            out_im_in  = t.q_im;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff     <= {vld_ff[VLD_W-2:0], q_pop};
         out_vld_ff <= vld_ff[VLD_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff      <= s1_in;
         s2_ff      <= s2_in;
         s3_ff      <= s3_in;
         s4_ff      <= s4_in;
         s5_ff      <= s5_in;
         s6_ff      <= s6_in;
         s7_ff      <= s7_in;
         d_ff       <= d_in;
         nr_ff      <= nr_in;
         ni_ff      <= ni_in;
         side_ff[0] <= s7_ff;
         for (int i = 1; i < DIV_LAT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
         out_re_ff  <= out_re_in;
         out_im_ff  <= out_im_in;
         out_ovf_ff <= out_ovf_in;
         out_dz_ff  <= out_dz_in;
      end
   end

   assign rsp_ch.valid          = out_vld_ff;
   assign rsp_ch.next_re        = out_re_ff;
   assign rsp_ch.next_im        = out_im_ff;
   assign rsp_ch.overflow       = out_ovf_ff;
   assign rsp_ch.divide_by_zero = out_dz_ff;

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && out_dz_ff) |-> (out_re_ff == '0 && out_im_ff == '0))
      else $error("zero divisor item with nonzero result");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipeline moved while stalled");

endmodule

FILE: hw/rtl/fractal_iteration_step_unit.sv
// ----------------------------------------------------------------------------
// fractal_iteration_step_unit: escape-time fractal iteration step
// Takes one item per cycle when the result side keeps up and returns the next z
// after the item is accepted: the combinational front, the 4-item queue, seven
// arithmetic stages and a pipelined divider with a one-bit-per-stage quotient
// lie on the way; every mode takes the same path, so results leave in order.
// Throughput is one item per clock when the result side keeps up. The cubic
// offset sits at byte address 0.
// ----------------------------------------------------------------------------
module fractal_iteration_step_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   fis_req_if.sink                               req_ch,
   fis_rsp_if.source                             rsp_ch,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [fis_pkg::CSR_ADDR_WIDTH-1:0]    paddr,
   input  logic [fis_pkg::CSR_DATA_WIDTH-1:0]    pwdata,
   output logic [fis_pkg::CSR_DATA_WIDTH-1:0]    prdata,
   output logic                                  pready
);
   import fis_pkg::*;

   word_type        offset_ff, offset_in;
   logic            csr_hit;
   logic            q_push, q_full, q_pop, q_empty;
   queue_entry_type wr_entry, rd_entry;

   assign pready  = 1'b1;
   assign csr_hit = paddr[2] == CSR_IDX_OFFSET;
   assign prdata  = csr_hit ? offset_ff : '0;

   always_comb begin
      offset_in = offset_ff;
      if (psel && penable && pwrite && csr_hit) begin
         offset_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= OFFSET_RESET;
      end else begin
         offset_ff <= offset_in;
      end
   end

   fis_front u_front (
      .req_ch       (req_ch),
      .cubic_offset (offset_ff),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_entry      (wr_entry)
   );

   fis_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .wr_entry (wr_entry),
      .full     (q_full),
      .pop      (q_pop),
      .rd_entry (rd_entry),
      .empty    (q_empty)
   );

   fis_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_entry (rd_entry),
      .q_empty (q_empty),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

FILE: tb/tb_fractal_iteration_step_unit.sv
// ----------------------------------------------------------------------------
// tb_fractal_iteration_step_unit: testbench of the fractal iteration step
// Drives iteration items through the request channel with random source and
// sink stalls, predicts each next z in Q4.28 with saturation, and compares
// every result in order. The cubic offset is swept over several settings,
// the extremes among them, and read back after each write.
// ----------------------------------------------------------------------------
module tb_fractal_iteration_step_unit;
   import fis_pkg::*;

   localparam longint W_MAX = 64'sd2147483647;
   localparam longint W_MIN = -64'sd2147483648;
   localparam int     CYCLE_LIMIT = 400000;
   localparam word_type ONE = 32'sh1000_0000;

   typedef struct packed {
      word_type re;
      word_type im;
      logic     ovf;
      logic     dz;
   } step_result_type;

   typedef struct packed {
      logic [2:0]      func;
      word_type        z_re;
      word_type        z_im;
      word_type        c_re;
      word_type        c_im;
      logic            chk;
      step_result_type res;
   } step_row_type;

   localparam int NUM_ROWS = 18;
   localparam step_row_type ROWS [NUM_ROWS] = '{
      '{3'd0, 0, 0, 0, 0, 1'b1, '{0, 0, 1'b0, 1'b0}},
      '{3'd1, 0, 0, WORD_MAX, 0, 1'b1, '{WORD_MAX, 0, 1'b0, 1'b0}},
      '{3'd5, 0, 0, WORD_MIN, WORD_MIN, 1'b1, '{WORD_MIN, WORD_MIN, 1'b0, 1'b0}},
      '{3'd6, ONE, 0, 0, 0, 1'b1, '{ONE, 0, 1'b0, 1'b0}},
      '{3'd7, 0, ONE, 0, 0, 1'b1, '{-ONE, 0, 1'b0, 1'b0}},
      '{3'd0, WORD_MAX, WORD_MAX, 0, 0, 1'b0, '0},
      '{3'd0, WORD_MIN, WORD_MIN, 0, 0, 1'b0, '0},
      '{FUNC_SHIP, WORD_MIN, 0, 0, 0, 1'b1, '{WORD_MAX, 0, 1'b1, 1'b0}},
      '{FUNC_SHIP, -ONE, -ONE, 0, 0, 1'b1, '{0, 32'sh2000_0000, 1'b0, 1'b0}},
      '{FUNC_SHIP, 32'shf345_6789, 32'sh0abc_def1, 32'sh0123_4567, -ONE, 1'b0, '0},
      '{FUNC_CUBIC, 0, 0, 0, 0, 1'b1, '{OFFSET_RESET, 0, 1'b0, 1'b0}},
      '{FUNC_CUBIC, 0, 0, ONE, 0, 1'b0, '0},
      '{FUNC_CDIV, 0, 0, ONE, 0, 1'b0, '0},
      '{FUNC_CDIV, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, 1'b0, '0},
      '{FUNC_CDIV, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, 1'b0, '0},
      '{3'd0, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MIN, 1'b0, '0},
      '{FUNC_CUBIC, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, 1'b0, '0},
      '{3'd0, -32'sd1, -32'sd1, 0, 0, 1'b0, '0}
   };

   logic clock;
   logic reset;
   logic psel, penable, pwrite, pready;
   logic [CSR_ADDR_WIDTH-1:0] paddr;
   logic [CSR_DATA_WIDTH-1:0] pwdata, prdata;

   fis_req_if req_if ();
   fis_rsp_if rsp_if ();

   fractal_iteration_step_unit i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_if.sink),
      .rsp_ch  (rsp_if.source),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   step_result_type next_z_q [$];
   word_type     offset_reg;
   int           errors;
   int           cycles;
   int           sent;
   int           received;
   int           dz_seen;
   int           ovf_seen;
   bit           no_idle;
   int           sink_stall;

   initial begin
      clock = 1'b0;
   end

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // saturating Q4.28 arithmetic
   function automatic longint clampw(longint x, inout bit ovf);
      if (x > W_MAX) begin
         ovf = 1'b1;
         return W_MAX;
      end
      if (x < W_MIN) begin
         ovf = 1'b1;
         return W_MIN;
      end
      return x;
   endfunction

   function automatic longint fx_add(longint a, longint b, inout bit ovf);
      return clampw(a + b, ovf);
   endfunction

   function automatic longint fx_sub(longint a, longint b, inout bit ovf);
      return clampw(a - b, ovf);
   endfunction

   function automatic longint fx_mul(longint a, longint b, inout bit ovf);
      longint p;
      p = a * b;
      return clampw(p >>> FRAC_BITS, ovf);
   endfunction

   function automatic longint fx_abs(longint a, inout bit ovf);
      return (a < 0) ? clampw(-a, ovf) : a;
   endfunction

   function automatic longint fx_div(longint n, longint d, inout bit ovf);
      longint m, q, r;
      m = ((n < 0) ? -n : n) <<< FRAC_BITS;
      q = m / d;
      r = m % d;
      if (n < 0) begin
         if (r != 0) q = q + 1;
         q = -q;
      end
      return clampw(q, ovf);
   endfunction

   task automatic cx_mul(input longint ar, ai, br, bi, output longint rr, ri,
                         inout bit ovf);
      longint t0, t1;
      t0 = fx_mul(ar, br, ovf);
      t1 = fx_mul(ai, bi, ovf);
      rr = fx_sub(t0, t1, ovf);
      t0 = fx_mul(ar, bi, ovf);
      t1 = fx_mul(ai, br, ovf);
      ri = fx_add(t0, t1, ovf);
   endtask

   task automatic predict_next_z(input logic [2:0] func, input word_type zr, zi, cr, ci,
                                 output step_result_type res);
      bit ovf;
      longint a, b, k, zzr, zzi, ccr, cci, c3r, c3i, sr, si, d, nr, ni, t0, t1, rr, ri;
      ovf = 1'b0;
      a = zr;
      b = zi;
      k = offset_reg;
      res.dz = 1'b0;
      if (func == FUNC_SHIP) begin
         a = fx_abs(a, ovf);
         b = fx_abs(b, ovf);
      end
      cx_mul(a, b, a, b, zzr, zzi, ovf);
      if (func == FUNC_CDIV || func == FUNC_CUBIC) begin
         cx_mul(cr, ci, cr, ci, ccr, cci, ovf);
         cx_mul(ccr, cci, cr, ci, c3r, c3i, ovf);
         t0 = fx_add(zzr, c3r, ovf);
         sr = fx_add(t0, k, ovf);
         si = fx_add(zzi, c3i, ovf);
         if (func == FUNC_CUBIC) begin
            rr = sr;
            ri = si;
         end else begin
            t0 = fx_mul(sr, sr, ovf);
            t1 = fx_mul(si, si, ovf);
            d = fx_add(t0, t1, ovf);
            if (d <= 0) begin
               res.dz = 1'b1;
               rr = 0;
               ri = 0;
            end else begin
               t0 = fx_mul(c3r, sr, ovf);
               t1 = fx_mul(c3i, si, ovf);
               nr = fx_add(t0, t1, ovf);
               t0 = fx_mul(c3i, sr, ovf);
               t1 = fx_mul(c3r, si, ovf);
               ni = fx_sub(t0, t1, ovf);
               rr = fx_div(nr, d, ovf);
               ri = fx_div(ni, d, ovf);
            end
         end
      end else begin
         rr = fx_add(zzr, cr, ovf);
         ri = fx_add(zzi, ci, ovf);
      end
      res.re = rr[31:0];
      res.im = ri[31:0];
      res.ovf = ovf;
   endtask

   function automatic word_type rand_word();
      int sel;
      sel = $urandom_range(0, 19);
      if (sel < 5) return $urandom();
      if (sel < 17) return word_type'(int'($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000);
      if (sel == 17) return word_type'(int'($urandom_range(0, 64)) - 32);
      if (sel == 18) return WORD_MAX;
      return WORD_MIN;
   endfunction

   task automatic push_step(input logic [2:0] func, input word_type zr, zi, cr, ci,
                            input logic chk, input step_result_type typed);
      step_result_type res;
      int gap;
      @(negedge clock);
      if (!no_idle && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 16);
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.func  <= func;
      req_if.z_re  <= zr;
      req_if.z_im  <= zi;
      req_if.c_re  <= cr;
      req_if.c_im  <= ci;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      if (chk) res = typed;
      else predict_next_z(func, zr, zi, cr, ci, res);
      next_z_q.push_back(res);
      sent++;
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (next_z_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_offset(input word_type val);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_WIDTH'(CSR_IDX_OFFSET);
      pwdata  <= val;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      offset_reg = val;
      @(negedge clock);
      psel    <= 1'b1;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== val) begin
         $display("%0t: offset readback expected %h actual %h", $time, val, prdata);
         errors++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic random_steps(input int n);
      logic [2:0] func;
      repeat (n) begin
         func = ($urandom_range(0, 3) == 0) ? FUNC_CDIV : 3'($urandom());
         push_step(func, rand_word(), rand_word(), rand_word(), rand_word(), 1'b0, '0);
      end
   endtask

   always @(negedge clock) begin
      if (no_idle || reset) begin
         rsp_if.ready <= 1'b1;
         sink_stall = 0;
      end else if (sink_stall > 0) begin
         sink_stall--;
         rsp_if.ready <= (sink_stall == 0);
      end else if ($urandom_range(0, 5) == 0) begin
         sink_stall = $urandom_range(1, 16);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      step_result_type exp_res;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         received++;
         if (next_z_q.size() == 0) begin
            $display("%0t: unexpected item re %h im %h", $time, rsp_if.next_re,
                     rsp_if.next_im);
            errors++;
         end else begin
            exp_res = next_z_q.pop_front();
            if (exp_res.dz) dz_seen++;
            if (exp_res.ovf) ovf_seen++;
            if (rsp_if.next_re !== exp_res.re) begin
               $display("%0t: next_re expected %h actual %h", $time, exp_res.re,
                        rsp_if.next_re);
               errors++;
            end
            if (rsp_if.next_im !== exp_res.im) begin
               $display("%0t: next_im expected %h actual %h", $time, exp_res.im,
                        rsp_if.next_im);
               errors++;
            end
            if (rsp_if.overflow !== exp_res.ovf) begin
               $display("%0t: overflow expected %b actual %b", $time, exp_res.ovf,
                        rsp_if.overflow);
               errors++;
            end
            if (rsp_if.divide_by_zero !== exp_res.dz) begin
               $display("%0t: divide_by_zero expected %b actual %b", $time, exp_res.dz,
                        rsp_if.divide_by_zero);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout with %0d items outstanding", next_z_q.size());
         $display("** fractal_iteration_step_unit: FAILED **");
         $finish;
      end
   end

   initial begin
      errors = 0;
      sent = 0;
      received = 0;
      dz_seen = 0;
      ovf_seen = 0;
      no_idle = 1'b0;
      offset_reg = OFFSET_RESET;
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_if.valid = 1'b0;
      req_if.func = '0;
      req_if.z_re = '0;
      req_if.z_im = '0;
      req_if.c_re = '0;
      req_if.c_im = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NUM_ROWS; i++) begin
         push_step(ROWS[i].func, ROWS[i].z_re, ROWS[i].z_im, ROWS[i].c_re, ROWS[i].c_im,
                   ROWS[i].chk, ROWS[i].res);
      end
      random_steps(80);
      drain_results();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: write_offset(0);
            1: write_offset(WORD_MAX);
            2: write_offset(WORD_MIN);
            3: write_offset(-ONE);
            default: write_offset($urandom());
         endcase
         if (phase == 5) no_idle = 1'b1;
         if (phase == 0) begin
            push_step(FUNC_CDIV, 0, 0, 0, 0, 1'b1, '{0, 0, 1'b0, 1'b1});
            push_step(FUNC_CDIV, 32'sd5, -32'sd3, 32'sd2, 32'sd1, 1'b0, '0);
         end
         random_steps(95);
         drain_results();
      end

      repeat (60) @(posedge clock);
      $display("sent %0d items, checked %0d, over 7 offset settings", sent, received);
      $display("%0d results saturated, %0d hit a zero divisor", ovf_seen, dz_seen);
      if (errors == 0) begin
         $display("** fractal_iteration_step_unit: PASSED **");
      end else begin
         $display("** fractal_iteration_step_unit: FAILED **");
      end
      $finish;
   end

endmodule
